// ----- sv/sled_pkg.sv -----
// ----------------------------------------------------------------------------
// sled_pkg
// Shared types, constants and helpers of the string literal escape decoder.
// ----------------------------------------------------------------------------
package sled_pkg;

  // width of the internal decoded byte counter
  localparam int LENGTH_BITS = 16;
  // width of the decoded_length result field
  localparam int LEN_OUT_W   = 16;
  // depth of the queue between front and back
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  // character codes
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ESC    = 8'd27;

  // scanner state, one-hot
  typedef enum logic [5:0] {
    M_OUT_UNKNOWN = 6'b000001,
    M_OUT_KNOWN   = 6'b000010,
    M_INSIDE      = 6'b000100,
    M_ESCAPE      = 6'b001000,
    M_HEX         = 6'b010000,
    M_OCTAL       = 6'b100000
  } mode_t;

  typedef logic [LENGTH_BITS-1:0] count_t;

  // one result transaction
  typedef struct packed {
    logic [7:0]           out_byte;
    logic                 byte_valid;
    logic                 final_result;
    logic [LEN_OUT_W-1:0] decoded_length;
  } result_t;

  // one queue entry: the results caused by one input byte
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  // queue status seen by both sides
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // counter value as it shows in the length field, saturating
  function automatic logic [LEN_OUT_W-1:0] len_field(input count_t c);
    logic [31:0] w;
    w = 32'(c);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[LEN_OUT_W-1:0];
  endfunction

  // saturating counter increment
  function automatic count_t sat_inc(input count_t c);
    return (c == '1) ? c : c + count_t'(1);
  endfunction

endpackage

// ----- sv/sled_in_if.sv -----
// ----------------------------------------------------------------------------
// sled_in_if
// Raw lexeme byte channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sled_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

// ----- sv/sled_out_if.sv -----
// ----------------------------------------------------------------------------
// sled_out_if
// Decoded result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sled_out_if;
  import sled_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [7:0]           out_byte;
  logic                 byte_valid;
  logic                 final_result;
  logic [LEN_OUT_W-1:0] decoded_length;

  modport source (output valid, output out_byte, output byte_valid,
                  output final_result, output decoded_length, input ready);
  modport sink   (input valid, input out_byte, input byte_valid,
                  input final_result, input decoded_length, output ready);
endinterface

// ----- sv/sled_front.sv -----
// ----------------------------------------------------------------------------
// sled_front
// Accepts lexeme bytes, runs the quote/escape scanner and pushes the results
// of each byte as one queue entry.
// ----------------------------------------------------------------------------
module sled_front (
  input  logic              clk,
  input  logic              rst,
  sled_in_if.sink           lexeme,
  input  sled_pkg::q_stat_t q_stat,
  output logic              push,
  output sled_pkg::entry_t  push_entry
);
  import sled_pkg::*;

  mode_t      mode, mode_next;
  logic [7:0] quote_char, quote_char_next;
  logic       quote_known, quote_known_next;
  logic [7:0] escape_accum, escape_accum_next;
  logic [1:0] octal_count, octal_count_next;
  count_t     byte_count, byte_count_next;

  logic       accept;
  logic [7:0] b;
  logic       last;
  logic       ea, eb, do_inside;
  logic [7:0] ea_byte, eb_byte;
  logic [3:0] hex_val;
  count_t     c1, c2;
  result_t    res0, res1;

  // no transaction is taken while reset is held
  assign lexeme.ready = !q_stat.full && !rst;
  assign accept       = lexeme.valid && lexeme.ready;
  assign b            = lexeme.in_byte;
  assign last         = lexeme.end_of_text;
  assign hex_val      = (b inside {["0":"9"]}) ? b[3:0] : b[3:0] + 4'd9;

  // scanner next state and emitted bytes
  always_comb begin
    mode_next         = mode;
    quote_char_next   = quote_char;
    quote_known_next  = quote_known;
    escape_accum_next = escape_accum;
    octal_count_next  = octal_count;
    ea                = 1'b0;
    ea_byte           = 8'h00;
    eb                = 1'b0;
    eb_byte           = 8'h00;
    do_inside         = 1'b0;
    case (mode)
      M_OUT_KNOWN: begin
        if (b == quote_char) mode_next = M_INSIDE;
      end
      M_INSIDE: begin
        do_inside = 1'b1;
      end
      M_ESCAPE: begin
        mode_next = M_INSIDE;
        case (b)
          "n":     begin ea = 1'b1; ea_byte = 8'd10; end
          "t":     begin ea = 1'b1; ea_byte = 8'd9;  end
          "r":     begin ea = 1'b1; ea_byte = 8'd13; end
          "a":     begin ea = 1'b1; ea_byte = 8'd7;  end
          "b":     begin ea = 1'b1; ea_byte = 8'd8;  end
          "f":     begin ea = 1'b1; ea_byte = 8'd12; end
          "v":     begin ea = 1'b1; ea_byte = 8'd11; end
          "e":     begin ea = 1'b1; ea_byte = CH_ESC; end
          "x": begin
            escape_accum_next = 8'h00;
            mode_next         = M_HEX;
          end
          default: begin
            if (b inside {["0":"7"]}) begin
              escape_accum_next = {5'b00000, b[2:0]};
              octal_count_next  = 2'd1;
              mode_next         = M_OCTAL;
            end else begin
              ea      = 1'b1;
              ea_byte = b;
            end
          end
        endcase
      end
      M_HEX: begin
        if (b inside {["0":"9"], ["a":"f"], ["A":"F"]}) begin
          escape_accum_next = {escape_accum[3:0], hex_val};
        end else begin
          ea        = 1'b1;
          ea_byte   = escape_accum;
          mode_next = M_INSIDE;
          do_inside = 1'b1;
        end
      end
      M_OCTAL: begin
        if (b inside {["0":"7"]}) begin
          escape_accum_next = {escape_accum[4:0], b[2:0]};
          if (octal_count == 2'd2) begin
            // third digit closes the escape at once
            ea               = 1'b1;
            ea_byte          = escape_accum_next;
            octal_count_next = 2'd0;
            mode_next        = M_INSIDE;
          end else begin
            octal_count_next = octal_count + 2'd1;
          end
        end else begin
          ea               = 1'b1;
          ea_byte          = escape_accum;
          octal_count_next = 2'd0;
          mode_next        = M_INSIDE;
          do_inside        = 1'b1;
        end
      end
      default: begin
        mode_next = M_OUT_UNKNOWN;
        if (!quote_known && (b == CH_DQUOTE || b == CH_SQUOTE)) begin
          quote_char_next  = b;
          quote_known_next = 1'b1;
          mode_next        = M_INSIDE;
        end
      end
    endcase

    // ordinary byte inside quotes
    if (do_inside) begin
      if (b == quote_char) begin
        mode_next = M_OUT_KNOWN;
      end else if (b == CH_BSLASH) begin
        mode_next = M_ESCAPE;
      end else begin
        eb      = 1'b1;
        eb_byte = b;
      end
    end

    // pending numeric escape flushed at end of text
    if (last && (mode_next == M_HEX || mode_next == M_OCTAL)) begin
      ea      = 1'b1;
      ea_byte = escape_accum_next;
    end
  end

  // pack the results of this byte
  assign c1 = sat_inc(byte_count);
  assign c2 = sat_inc(c1);

  always_comb begin
    res0            = '0;
    res1            = '0;
    byte_count_next = byte_count;
    if (ea && eb) begin
      res0            = '{ea_byte, 1'b1, 1'b0, len_field(c1)};
      res1            = '{eb_byte, 1'b1, last, len_field(c2)};
      byte_count_next = c2;
    end else if (ea || eb) begin
      res0            = '{(ea ? ea_byte : eb_byte), 1'b1, last, len_field(c1)};
      byte_count_next = c1;
    end else begin
      // end-only marker
      res0 = '{8'h00, 1'b0, last, len_field(byte_count)};
    end
  end

  assign push       = accept && (ea || eb || last);
  assign push_entry = '{(ea && eb), res0, res1};

  // scanner registers
  always_ff @(posedge clk) begin
    if (rst || (accept && last)) begin
      mode         <= M_OUT_UNKNOWN;
      quote_char   <= CH_DQUOTE;
      quote_known  <= 1'b0;
      escape_accum <= 8'h00;
      octal_count  <= 2'd0;
      byte_count   <= '0;
    end else if (accept) begin
      mode         <= mode_next;
      quote_char   <= quote_char_next;
      quote_known  <= quote_known_next;
      escape_accum <= escape_accum_next;
      octal_count  <= octal_count_next;
      byte_count   <= byte_count_next;
    end
  end

  // end of text returns the scanner to its starting state
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && last |=> mode == M_OUT_UNKNOWN && byte_count == '0)
    else $error("scanner not cleared after end of text");

  // octal digit count only runs inside an octal escape
  a_octal_count: assert property (@(posedge clk) disable iff (rst)
    octal_count != 2'd0 |-> mode == M_OCTAL)
    else $error("octal digit count outside octal escape");

endmodule

// ----- sv/sled_queue.sv -----
// ----------------------------------------------------------------------------
// sled_queue
// Short register queue of result entries between front and back.
// ----------------------------------------------------------------------------
module sled_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sled_pkg::entry_t  push_entry,
  input  logic              pop,
  output sled_pkg::entry_t  head,
  output sled_pkg::q_stat_t q_stat
);
  import sled_pkg::*;

  entry_t            slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign q_stat.empty = (count == '0);
  assign q_stat.full  = (count == QCNT_W'(QDEPTH));
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = slots[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_entry;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && q_stat.full))
    else $error("push into full queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");

endmodule

// ----- sv/sled_back.sv -----
// ----------------------------------------------------------------------------
// sled_back
// Drains queue entries to the output register, one result per cycle while ready.
// ----------------------------------------------------------------------------
module sled_back (
  input  logic              clk,
  input  logic              rst,
  input  sled_pkg::entry_t  head,
  input  sled_pkg::q_stat_t q_stat,
  output logic              pop,
  sled_out_if.source        decoded
);
  import sled_pkg::*;

  logic    sel;
  logic    load;
  logic    out_valid;
  result_t out_reg;
  result_t pick;

  assign load = (!out_valid || decoded.ready) && !q_stat.empty;
  assign pop  = load && (sel || !head.two);
  assign pick = sel ? head.r1 : head.r0;

  // output register and second-result select
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        sel       <= !sel && head.two;
      end else if (decoded.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_reg <= pick;
  end

  assign decoded.valid          = out_valid;
  assign decoded.out_byte       = out_reg.out_byte;
  assign decoded.byte_valid     = out_reg.byte_valid;
  assign decoded.final_result   = out_reg.final_result;
  assign decoded.decoded_length = out_reg.decoded_length;

  // second result is only selected while its entry waits at the head
  a_sel_head: assert property (@(posedge clk) disable iff (rst)
    sel |-> !q_stat.empty && head.two)
    else $error("second result selected without a pair entry");

endmodule

// ----- sv/string_literal_escape_decoder.sv -----
// ----------------------------------------------------------------------------
// string_literal_escape_decoder
// Path: each accepted byte's results pass through the queue, then the output register.
// Throughput: one byte per cycle while the queue is not full; a byte with two
// results fills the output twice, absorbed by the 4-entry queue in between.
// Reset: synchronous rst clears scanner, queue and output valid flag; the first
// byte may be accepted in the cycle after reset is released.
// ----------------------------------------------------------------------------
module string_literal_escape_decoder (
  input  logic       clk,
  input  logic       rst,
  sled_in_if.sink    lexeme,
  sled_out_if.source decoded
);
  import sled_pkg::*;

  logic    push, pop;
  entry_t  push_entry, head;
  q_stat_t q_stat;

  // scanner
  sled_front u_front (
    .clk        (clk),
    .rst        (rst),
    .lexeme     (lexeme),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  // decoupling queue
  sled_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  // output side
  sled_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_stat  (q_stat),
    .pop     (pop),
    .decoded (decoded)
  );

endmodule
